/* sv/tabt_pkg.sv */
// Package for the timed address block table: sizes, action codes and the
// structs that pass between the top level, the table cells and the time splitter.
// Depends on nothing.
package tabt_pkg;

  localparam int ENTRIES = 32;
  localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

  localparam logic [1:0] ACT_LOOKUP = 2'd0;
  localparam logic [1:0] ACT_ADD    = 2'd1;
  localparam logic [1:0] ACT_REMOVE = 2'd2;

  typedef logic [IDX_W-1:0] idx_t;

  // Search token that walks down the row of cells, one cell per cycle.
  typedef struct packed {
    logic        valid;
    logic [1:0]  action;
    logic [31:0] addr;
    logic [31:0] now;
    logic        found;
    idx_t        found_idx;
    logic [31:0] oldest_stamp;
    idx_t        oldest_idx;
    logic        hit;
    logic [7:0]  hit_msg;
    logic [31:0] left;
  } token_t;

  // Write or clear command broadcast to every cell.
  typedef struct packed {
    logic        en;
    logic        clr;
    idx_t        slot;
    logic [31:0] addr;
    logic [7:0]  msg;
    logic [31:0] timeout;
    logic [31:0] stamp;
  } wr_t;

  // Result of the time splitter.
  typedef struct packed {
    logic       done;
    logic [3:0] days;
    logic [4:0] hours;
    logic [5:0] minutes;
  } split_res_t;

endpackage

/* sv/timed_address_block_table_unit.sv */
// Top level of the timed address block table: item command port, APB
// register port, row of table cells and the time splitter.
// Depends on tabt_pkg, tabt_cell and tabt_split.
//
// Usage. A request is taken on the rising edge where start is high and busy
// is low; its fields are in_action, in_addr, in_now_secs, in_stamp_ms,
// in_expire_time and in_message_id. busy falls in the cycle in which the
// result is shown, so one request is worked on at a time. Each request gives
// one result, shown for a single cycle with out_valid high; the receiver
// cannot hold it off, so it must take it in that cycle.
// The request passes the states S_DIFF and S_TMO to work out the new
// timeout, then a search token walks the row of ENTRIES cells at one cell
// per cycle. A lookup that hits then passes through the time splitter, which
// works out days, hours and minutes by reciprocal multiplication. A new
// request is taken only once the result of the last one is shown.
// The register max_ban_minutes lies at byte address 0; the user must write it
// only while busy is low, as the block itself does not enforce this. Reset
// clears every entry and its stamp at once and loads the limit with 240
// minutes; no clearing pass is needed.
module timed_address_block_table_unit (
  input  logic               clk,
  input  logic               rst_n,
  // Request channel
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         in_action,
  input  logic [31:0]        in_addr,
  input  logic [31:0]        in_now_secs,
  input  logic [31:0]        in_stamp_ms,
  input  logic signed [31:0] in_expire_time,
  input  logic [7:0]         in_message_id,
  // Result channel
  output logic               out_valid,
  output logic               out_hit,
  output logic [7:0]         out_hit_message_id,
  output logic [3:0]         out_days_left,
  output logic [4:0]         out_hours_left,
  output logic [5:0]         out_minutes_left,
  // Register port
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);
  import tabt_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_DIFF  = 3'd1;
  localparam logic [2:0] S_TMO   = 3'd2;
  localparam logic [2:0] S_SCAN  = 3'd3;
  localparam logic [2:0] S_SPLIT = 3'd4;

  logic [2:0]  state_r;
  logic [2:0]  state_nxt;
  logic [14:0] max_r;

  // Fields of the request in work.
  logic [1:0]  act_r;
  logic [31:0] addr_r;
  logic [31:0] now_r;
  logic [31:0] stamp_r;
  logic [31:0] expire_r;
  logic [7:0]  msg_r;
  logic [31:0] diff_r;
  logic [31:0] timeout_r;
  logic [7:0]  hit_msg_r;

  logic        out_valid_r;
  logic        out_hit_r;
  logic [7:0]  out_msg_r;
  logic [3:0]  out_days_r;
  logic [4:0]  out_hours_r;
  logic [5:0]  out_min_r;

  logic        accept;
  logic        cfg_wr;
  logic [20:0] limit;
  logic [31:0] duration;
  token_t      head;
  token_t      chain [ENTRIES+1];
  token_t      tail;
  wr_t         wr;
  logic        split_start;
  split_res_t  split_res;
  logic        scan_end;

  assign accept = start && (state_r == S_IDLE);
  assign busy   = (state_r != S_IDLE);

  // The register port always completes in the access cycle.
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && !paddr[2];
  assign prdata = paddr[2] ? 32'd0 : {17'd0, max_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_r <= 15'd240;
    end else if (cfg_wr) begin
      max_r <= pwdata[14:0];
    end
  end

  // Limit in seconds is max_ban_minutes times 60, built from two shifts.
  assign limit = {max_r, 6'd0} - {4'd0, max_r, 2'd0};

  // A duration longer than the limit, or a permanent block, is cut to the
  // limit; a negative duration stands and yields an entry already expired.
  assign duration = (($signed(diff_r) > $signed({11'd0, limit})) || (expire_r == 32'hFFFF_FFFF))
                    ? {11'd0, limit} : diff_r;

  always_ff @(posedge clk) begin
    if (accept) begin
      act_r    <= in_action;
      addr_r   <= in_addr;
      now_r    <= in_now_secs;
      stamp_r  <= in_stamp_ms;
      expire_r <= in_expire_time;
      msg_r    <= in_message_id;
    end
    if (state_r == S_DIFF) begin
      diff_r <= expire_r - now_r;
    end
    if (state_r == S_TMO) begin
      timeout_r <= now_r + duration;
    end
    if (split_start) begin
      hit_msg_r <= tail.hit_msg;
    end
  end

  // The token is presented to the first cell in S_TMO, while the timeout is registered.
  always_comb begin
    head              = '0;
    head.valid        = (state_r == S_TMO);
    head.action       = act_r;
    head.addr         = addr_r;
    head.now          = now_r;
    head.oldest_stamp = 32'hFFFF_FFFF;
  end

  assign chain[0] = head;

  for (genvar k = 0; k < ENTRIES; k++) begin : g_cell
    tabt_cell u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .idx     (IDX_W'(k)),
      .tok_in  (chain[k]),
      .wr      (wr),
      .tok_out (chain[k+1])
    );
  end

  assign tail     = chain[ENTRIES];
  assign scan_end = (state_r == S_SCAN) && tail.valid;

  // When the token leaves the last cell, an add with a non-zero limit writes
  // the matching slot or the oldest one; a remove clears the matching one, if any.
  always_comb begin
    wr         = '0;
    wr.slot    = tail.found ? tail.found_idx : tail.oldest_idx;
    wr.addr    = addr_r;
    wr.msg     = msg_r;
    wr.timeout = timeout_r;
    wr.stamp   = stamp_r;
    wr.clr     = (act_r == ACT_REMOVE);
    if (scan_end) begin
      if (act_r == ACT_ADD) begin
        wr.en = (max_r != 15'd0);
      end else if (act_r == ACT_REMOVE) begin
        wr.en = tail.found;
      end
    end
  end

  assign split_start = scan_end && (act_r == ACT_LOOKUP) && tail.hit;

  tabt_split u_split (
    .clk   (clk),
    .rst_n (rst_n),
    .start (split_start),
    .left  (tail.left),
    .res   (split_res)
  );

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:  if (accept) state_nxt = S_DIFF;
      S_DIFF:  state_nxt = S_TMO;
      S_TMO:   state_nxt = S_SCAN;
      S_SCAN: begin
        if (split_start) begin
          state_nxt = S_SPLIT;
        end else if (scan_end) begin
          state_nxt = S_IDLE;
        end
      end
      S_SPLIT: if (split_res.done) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= (scan_end && !split_start) || ((state_r == S_SPLIT) && split_res.done);
    end
  end

  // Misses, adds and removes report all zeros.
  always_ff @(posedge clk) begin
    if ((state_r == S_SPLIT) && split_res.done) begin
      out_hit_r   <= 1'b1;
      out_msg_r   <= hit_msg_r;
      out_days_r  <= split_res.days;
      out_hours_r <= split_res.hours;
      out_min_r   <= split_res.minutes;
    end else if (scan_end) begin
      out_hit_r   <= 1'b0;
      out_msg_r   <= '0;
      out_days_r  <= '0;
      out_hours_r <= '0;
      out_min_r   <= '0;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_hit            = out_hit_r;
  assign out_hit_message_id = out_msg_r;
  assign out_days_left      = out_days_r;
  assign out_hours_left     = out_hours_r;
  assign out_minutes_left   = out_min_r;

  // A result is only shown once the request has been retired.
  a_result_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result shown while a request is still in work");

  // An accepted request holds the block busy in the next cycle.
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("accepted request did not raise busy");

  // A result without a hit carries no time or message.
  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_hit) |-> ((out_hit_message_id == 8'd0) && (out_days_left == 4'd0)
      && (out_hours_left == 5'd0) && (out_minutes_left == 6'd0)))
    else $error("miss result carries non-zero fields");

  // The splitter leaves hours and minutes in range.
  a_split_range: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_hit) |-> ((out_hours_left < 5'd24) && (out_minutes_left < 6'd60)))
    else $error("hours or minutes out of range");

  // The splitter finishes only while the block waits for it.
  a_split_done_state: assert property (@(posedge clk) disable iff (!rst_n)
    split_res.done |-> (state_r == S_SPLIT))
    else $error("divider finished outside its wait state");

endmodule

/* sv/tabt_cell.sv */
// One table cell: holds a single entry and updates the passing search token.
// Depends on tabt_pkg.
module tabt_cell (
  input  logic            clk,
  input  logic            rst_n,
  input  tabt_pkg::idx_t  idx,
  input  tabt_pkg::token_t tok_in,
  input  tabt_pkg::wr_t   wr,
  output tabt_pkg::token_t tok_out
);
  import tabt_pkg::*;

  logic        valid_r;
  logic [31:0] addr_r;
  logic [7:0]  msg_r;
  logic [31:0] timeout_r;
  logic [31:0] stamp_r;
  token_t      tok_r;
  token_t      tok_nxt;
  logic        match;
  logic [31:0] left;

  assign match = valid_r && (addr_r == tok_in.addr);
  assign left  = timeout_r - tok_in.now;

  always_comb begin
    tok_nxt = tok_in;
    if (tok_in.action == ACT_LOOKUP) begin
      // Expired matches are passed over; the scan looks further down.
      if (!tok_in.hit && match && ($signed(left) > 32'sd1)) begin
        tok_nxt.hit     = 1'b1;
        tok_nxt.hit_msg = msg_r;
        tok_nxt.left    = left;
      end
    end else if (!tok_in.found) begin
      if (match) begin
        tok_nxt.found     = 1'b1;
        tok_nxt.found_idx = idx;
      end else if (stamp_r < tok_in.oldest_stamp) begin
        tok_nxt.oldest_stamp = stamp_r;
        tok_nxt.oldest_idx   = idx;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_r.valid <= 1'b0;
    end else begin
      tok_r <= tok_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      stamp_r <= '0;
    end else if (wr.en && (wr.slot == idx)) begin
      if (wr.clr) begin
        valid_r <= 1'b0;
        stamp_r <= '0;
      end else begin
        valid_r <= 1'b1;
        stamp_r <= wr.stamp;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr.en && (wr.slot == idx)) begin
      addr_r    <= wr.clr ? '0 : wr.addr;
      msg_r     <= wr.clr ? '0 : wr.msg;
      timeout_r <= wr.clr ? '0 : wr.timeout;
    end
  end

  assign tok_out = tok_r;

endmodule

/* sv/tabt_split.sv */
// Time splitter: turns remaining seconds plus one minute into days, hours and
// minutes by reciprocal multiplication; days saturate at 15. Depends on tabt_pkg.
module tabt_split (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic [31:0]         left,
  output tabt_pkg::split_res_t res
);
  import tabt_pkg::*;

  // Each quotient is the remainder, shifted right by the power of two in the
  // divisor, times a rounded-up reciprocal of the odd part: 86400 = 128*675,
  // 3600 = 16*225 and 60 = 4*15. The rounding error stays below one step over
  // the whole input range, so every quotient is exact.
  localparam logic [25:0] RCP_DAY   = 26'd50903317;  // 2^35 / 675, rounded up
  localparam logic [13:0] RCP_HOUR  = 14'd9321;      // 2^21 / 225, rounded up
  localparam logic [10:0] RCP_MIN   = 11'd1093;      // 2^14 / 15, rounded up
  localparam logic [16:0] SECS_DAY  = 17'd86400;
  localparam logic [11:0] SECS_HOUR = 12'd3600;

  localparam logic [2:0] STEP_DAY      = 3'd0;
  localparam logic [2:0] STEP_DAY_REM  = 3'd1;
  localparam logic [2:0] STEP_HOUR     = 3'd2;
  localparam logic [2:0] STEP_HOUR_REM = 3'd3;
  localparam logic [2:0] STEP_MIN      = 3'd4;

  logic        run_r;
  logic        done_r;
  logic [2:0]  step_r;
  logic [31:0] rem_r;
  logic [15:0] day_q_r;
  logic [16:0] day_rem_r;
  logic [4:0]  hour_q_r;
  logic [11:0] hour_rem_r;
  logic [5:0]  min_q_r;
  logic [50:0] day_prod;
  logic [31:0] day_secs;
  logic [31:0] day_rem;
  logic [26:0] hour_prod;
  logic [16:0] hour_secs;
  logic [16:0] hour_rem;
  logic [20:0] min_prod;

  assign day_prod  = 51'(rem_r[31:7]) * 51'(RCP_DAY);
  assign day_secs  = 32'(day_q_r) * 32'(SECS_DAY);
  assign day_rem   = rem_r - day_secs;
  assign hour_prod = 27'(day_rem_r[16:4]) * 27'(RCP_HOUR);
  assign hour_secs = 17'(hour_q_r) * 17'(SECS_HOUR);
  assign hour_rem  = day_rem_r - hour_secs;
  assign min_prod  = 21'(hour_rem_r[11:2]) * 21'(RCP_MIN);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        run_r  <= 1'b1;
        step_r <= STEP_DAY;
      end else if (run_r) begin
        step_r <= step_r + 3'd1;
        if (step_r == STEP_MIN) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // One multiply per cycle: a quotient, then the remainder that it leaves.
  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= left + 32'd60;
    end else if (run_r) begin
      unique case (step_r)
        STEP_DAY:      day_q_r    <= day_prod[50:35];
        STEP_DAY_REM:  day_rem_r  <= day_rem[16:0];
        STEP_HOUR:     hour_q_r   <= hour_prod[25:21];
        STEP_HOUR_REM: hour_rem_r <= hour_rem[11:0];
        STEP_MIN:      min_q_r    <= min_prod[19:14];
        default: ;
      endcase
    end
  end

  assign res.done    = done_r;
  assign res.days    = (day_q_r > 16'd15) ? 4'd15 : day_q_r[3:0];
  assign res.hours   = hour_q_r;
  assign res.minutes = min_q_r;

endmodule
